### rtl/core/ctc_pkg.sv
// Shared types and constants of the greedy CTC decoder.
// No dependencies; every other file of the decoder imports this package.
`default_nettype none

package ctc_pkg;

  localparam int PROB_W = 16;   // Q0.16 score
  localparam int IDX_W  = 13;   // vocabulary index
  localparam int SUM_W  = 23;   // score sum
  localparam int CNT_W  = 8;    // emitted character count

  localparam int DEF_VOCAB_LEN = 8192;
  localparam int DEF_MAX_STEPS = 128;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_AVG  = 1'b1;

  // Work handed from the front end to the back end for one input word.
  typedef struct packed {
    logic             has_char;
    logic [IDX_W-1:0] char_index;
    logic             has_avg;
    logic [SUM_W-1:0] score_sum;
    logic [CNT_W-1:0] char_total;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_DIV,
    ST_AVG
  } back_state_t;

endpackage

`default_nettype wire

### rtl/core/ctc_in_if.sv
// Score channel: one vocabulary score per word with row and sequence marks.
// Depends on ctc_pkg for field widths.
`default_nettype none

interface ctc_in_if
  import ctc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] prob_value;
  logic              end_of_step;
  logic              end_of_sequence;

  modport source (output valid, output prob_value, output end_of_step,
                  output end_of_sequence, input ready);
  modport sink   (input valid, input prob_value, input end_of_step,
                  input end_of_sequence, output ready);
endinterface

`default_nettype wire

### rtl/core/ctc_out_if.sv
// Result channel: emitted characters and the per-sequence average score.
// Depends on ctc_pkg for field widths.
`default_nettype none

interface ctc_out_if
  import ctc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [IDX_W-1:0]  char_index;
  logic [PROB_W-1:0] avg_score;
  logic [CNT_W-1:0]  char_total;
  logic              last_result;

  modport source (output valid, output kind, output char_index, output avg_score,
                  output char_total, output last_result, input ready);
  modport sink   (input valid, input kind, input char_index, input avg_score,
                  input char_total, input last_result, output ready);
endinterface

`default_nettype wire

### rtl/core/ctc_front.sv
// Front end: row argmax tracking, collapse of blanks and repeats, score sum.
// Depends on ctc_pkg and ctc_in_if; pushes commands into ctc_cmd_fifo.
`default_nettype none

module ctc_front
  import ctc_pkg::*;
#(
  parameter int VOCAB_LEN = DEF_VOCAB_LEN,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  ctc_in_if.sink          scores,
  input  wire fifo_stat_t fifo_stat,
  output logic            push,
  output cmd_t            cmd
);

  localparam int POS_W = $clog2(VOCAB_LEN + 1);

  logic [PROB_W-1:0] row_max, row_max_next;
  logic [IDX_W-1:0]  row_max_index, row_max_index_next;
  logic [POS_W-1:0]  entry_position, entry_position_next;
  logic [IDX_W-1:0]  prev_step_index, prev_step_index_next;
  logic [SUM_W-1:0]  score_sum, score_sum_next;
  logic [CNT_W-1:0]  emitted_count, emitted_count_next;

  logic              accept;
  logic              in_row;
  logic              take;
  logic              closing;
  logic              emit;
  logic [PROB_W-1:0] cur_max;
  logic [IDX_W-1:0]  cur_idx;
  logic [SUM_W-1:0]  sum_upd;
  logic [CNT_W-1:0]  cnt_upd;

  assign scores.ready = !fifo_stat.full;
  assign accept       = scores.valid && scores.ready;

  always_comb begin
    in_row  = entry_position < POS_W'(VOCAB_LEN);
    take    = in_row && (entry_position == '0 || scores.prob_value > row_max);
    cur_max = take ? scores.prob_value : row_max;
    cur_idx = take ? IDX_W'(entry_position) : row_max_index;
    closing = scores.end_of_step || scores.end_of_sequence;
    // drop blanks, repeats and anything past the character limit
    emit    = closing && cur_idx != '0 && cur_idx != prev_step_index &&
              emitted_count < CNT_W'(MAX_STEPS);
    sum_upd = emit ? score_sum + SUM_W'(cur_max) : score_sum;
    cnt_upd = emitted_count + CNT_W'(emit);

    push           = accept && (emit || scores.end_of_sequence);
    cmd.has_char   = emit;
    cmd.char_index = cur_idx;
    cmd.has_avg    = scores.end_of_sequence;
    cmd.score_sum  = sum_upd;
    cmd.char_total = cnt_upd;

    row_max_next         = row_max;
    row_max_index_next   = row_max_index;
    entry_position_next  = entry_position;
    prev_step_index_next = prev_step_index;
    score_sum_next       = score_sum;
    emitted_count_next   = emitted_count;
    if (accept) begin
      if (closing) begin
        row_max_next         = '0;
        row_max_index_next   = '0;
        entry_position_next  = '0;
        prev_step_index_next = scores.end_of_sequence ? '0 : cur_idx;
      end else begin
        row_max_next       = cur_max;
        row_max_index_next = cur_idx;
        if (in_row) begin
          entry_position_next = entry_position + POS_W'(1);
        end
      end
      if (scores.end_of_sequence) begin
        score_sum_next     = '0;
        emitted_count_next = '0;
      end else begin
        score_sum_next     = sum_upd;
        emitted_count_next = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_max         <= '0;
      row_max_index   <= '0;
      entry_position  <= '0;
      prev_step_index <= '0;
      score_sum       <= '0;
      emitted_count   <= '0;
    end else begin
      row_max         <= row_max_next;
      row_max_index   <= row_max_index_next;
      entry_position  <= entry_position_next;
      prev_step_index <= prev_step_index_next;
      score_sum       <= score_sum_next;
      emitted_count   <= emitted_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ctc_cmd_fifo.sv
// Short command queue between the decoder front end and back end.
// Depends on ctc_pkg for cmd_t and the queue depth.
`default_nettype none

module ctc_cmd_fifo
  import ctc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output fifo_stat_t stat
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] fill;

  assign head       = entries[rd_ptr];
  assign stat.full  = fill == CMD_CNT_W'(CMD_DEPTH);
  assign stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + CMD_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + CMD_PTR_W'(1);
      end
      fill <= fill + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### rtl/core/ctc_back.sv
// Back end: emits characters and computes the mean score with a serial divider.
// Depends on ctc_pkg and ctc_out_if; pops commands from ctc_cmd_fifo.
`default_nettype none

module ctc_back
  import ctc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire fifo_stat_t fifo_stat,
  output logic            pop,
  ctc_out_if.source       results
);

  back_state_t state, state_next;
  cmd_t        cmd;

  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] step;

  logic       slot_free;
  logic       load_char;
  logic       load_avg;
  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] diff;
  logic [PROB_W-1:0] avg;

  assign slot_free = !results.valid || results.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          state_next = head.has_char ? ST_CHAR : ST_DIV;
        end
      end
      ST_CHAR: begin
        if (slot_free) begin
          state_next = cmd.has_avg ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_AVG;
        end
      end
      ST_AVG: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    load_char = 1'b0;
    load_avg  = 1'b0;
    case (state)
      ST_IDLE: pop       = !fifo_stat.empty;
      ST_CHAR: load_char = slot_free;
      ST_AVG:  load_avg  = slot_free;
      default: ;
    endcase
  end

  // one restoring division step per cycle
  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    diff   = rem_sh - {1'b0, cmd.char_total};
    if (cmd.char_total == '0) begin
      avg = '0;
    end else if (quo[SUM_W-1:PROB_W] != '0) begin
      avg = '1;
    end else begin
      avg = quo[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd  <= head;
      quo  <= head.score_sum;
      rem  <= '0;
      step <= '0;
    end else if (state == ST_DIV) begin
      step <= step + DIV_CNT_W'(1);
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_char || load_avg) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_char) begin
      results.kind        <= KIND_CHAR;
      results.char_index  <= cmd.char_index;
      results.avg_score   <= '0;
      results.char_total  <= '0;
      results.last_result <= 1'b0;
    end else if (load_avg) begin
      results.kind        <= KIND_AVG;
      results.char_index  <= '0;
      results.avg_score   <= avg;
      results.char_total  <= cmd.char_total;
      results.last_result <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ctc_greedy_decoder.sv
// Top level of the greedy CTC decoder: front end, command queue, back end.
// Depends on ctc_pkg, ctc_in_if, ctc_out_if, ctc_front, ctc_cmd_fifo, ctc_back.
//
//   channel   modport  word
//   scores    sink     prob_value, end_of_step, end_of_sequence
//   results   source   kind, char_index, avg_score, char_total, last_result
//
// The front end takes one score word per cycle while the command queue has room.
// A character word passes from the command queue to the output register through
// the back-end command register. The average word waits on the serial divider,
// one quotient bit per cycle, which runs after any character of its command.
// Synchronous reset clears all control state; no clearing pass is needed.
// A stalled result holds the back end; the front end stalls once four commands wait.
`default_nettype none

module ctc_greedy_decoder
  import ctc_pkg::*;
#(
  parameter int VOCAB_LEN = DEF_VOCAB_LEN,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  wire logic clk,
  input  wire logic rst,
  ctc_in_if.sink    scores,
  ctc_out_if.source results
);

  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head;
  fifo_stat_t fifo_stat;

  ctc_front #(
    .VOCAB_LEN (VOCAB_LEN),
    .MAX_STEPS (MAX_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .scores    (scores),
    .fifo_stat (fifo_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  ctc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  ctc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .results   (results)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_stat.full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_stat.empty)
    else $error("command popped from an empty queue");

  a_char_not_blank: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.kind == KIND_CHAR) |-> results.char_index != '0)
    else $error("blank emitted as a character");
`endif

endmodule

`default_nettype wire
